@@ design/pqci_pkg.sv @@
// pqci_pkg: shared types and constants of the quantum-efficiency interpolator
// no dependencies
package pqci_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  // index quotient holds values below twice the depth, larger values flag overflow
  localparam int QI_W = IDX_W + 1;
  localparam int CNT_W = 9;
  localparam int CW = ((IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W) + 1;

  // wavelength division: 1240 * 2^28 / energy, quotient fits 29 bits above the energy floor
  localparam int LNUM_W = 39;
  localparam int LAM_W = 29;
  localparam logic [LNUM_W-1:0] LAMBDA_NUM = 39'd1240 << 28;
  localparam logic [23:0] ENERGY_MIN = 24'd1049;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CFG_FIRST_WL = 2'd0,
    CFG_STEP     = 2'd1,
    CFG_PEAK     = 2'd2,
    CFG_COUNT    = 2'd3
  } cfg_idx_t;

  // classified request as it travels from front to back
  typedef struct packed {
    logic        query;
    logic        low;
    logic [7:0]  idx;
    logic [15:0] val;
    logic [23:0] energy;
  } item_t;

endpackage

@@ design/pqci_front.sv @@
// pqci_front: input register that accepts and classifies requests
// depends on pqci_pkg
module pqci_front import pqci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  point_index,
  input  logic [15:0] point_value,
  input  logic [23:0] photon_energy,
  output item_t       item,
  output logic        item_valid,
  input  logic        item_ready
);

  // hold only while the queue refuses the held request
  assign in_stall = item_valid && !item_ready;

  // capture and classify
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      item.query  <= (cmd == CMD_QUERY);
      item.low    <= (photon_energy < ENERGY_MIN);
      item.idx    <= point_index;
      item.val    <= point_value;
      item.energy <= photon_energy;
    end
  end

endmodule

@@ design/pqci_queue.sv @@
// pqci_queue: short fifo between the front and the back pipeline
// depends on pqci_pkg
module pqci_queue import pqci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t push_item,
  input  logic  push_valid,
  output logic  push_ready,
  output item_t head,
  output logic  head_valid,
  input  logic  pop_req
);

  item_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               push;
  logic               pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_req && head_valid;
  assign head = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count lost a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1) else $error("count lost a pop");

endmodule

@@ design/pqci_back.sv @@
// pqci_back: pipelined wavelength divide, index divide, table, multiply and final divide
// depends on pqci_pkg
module pqci_back import pqci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  item_t       head,
  input  logic        head_valid,
  output logic        pop_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] efficiency
);

  localparam int DW = LAM_W + QI_W;

  typedef struct packed {
    logic             valid;
    item_t            item;
    logic [23:0]      rem;
    logic [LAM_W-1:0] quo;
  } lam_t;

  typedef struct packed {
    logic               valid;
    logic               query;
    logic               low;
    logic [7:0]         idx;
    logic [15:0]        val;
    logic               neg;
    logic               ovf;
    logic signed [LAM_W:0] dlam;
    logic [19:0]        rem;
    logic [QI_W-1:0]    quo;
  } ix_t;

  typedef struct packed {
    logic               valid;
    logic               query;
    logic               zero;
    logic signed [21:0] frac;
  } rd_t;

  typedef struct packed {
    logic        valid;
    logic        query;
    logic        zero;
    logic        pos;
    logic        ovf;
    logic [15:0] n;
    logic [19:0] rem;
    logic [15:0] quo;
  } fd_t;

  logic [19:0] first_wl;
  logic [19:0] step;
  logic [15:0] peak;
  logic [8:0]  point_count;

  logic adv;

  lam_t lam_head;
  lam_t lam_in [LAM_W];
  lam_t lam_r  [LAM_W];
  ix_t  ix_head;
  ix_t  ix_in  [QI_W+1];
  ix_t  ix_r   [QI_W+1];
  rd_t  rd_r;
  logic [15:0] t0;
  logic [15:0] t1;
  logic [15:0] table_mem [TABLE_DEPTH];

  logic        m1_valid, m1_query, m1_zero;
  logic [35:0] m1_p0;
  logic signed [38:0] m1_p1;
  logic        m2_valid, m2_query, m2_zero;
  logic signed [39:0] m2_v;
  logic        m3_valid, m3_query, m3_zero;
  logic signed [56:0] m3_num;

  fd_t  fd_head;
  fd_t  fd_in [17];
  fd_t  fd_r  [17];

  logic [CW-1:0]   cnt;
  logic [QI_W-1:0] rd_i;
  logic            rd_zero;
  logic [39:0]     fn;

  // one restoring step: returns quotient bit over remainder
  function automatic logic [24:0] step24(input logic [23:0] r, input logic b,
                                         input logic [23:0] d);
    logic [24:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, 24'(t - {1'b0, d})};
    return {1'b0, t[23:0]};
  endfunction

  function automatic logic [20:0] step20(input logic [19:0] r, input logic b,
                                         input logic [19:0] d);
    logic [20:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, 20'(t - {1'b0, d})};
    return {1'b0, t[19:0]};
  endfunction

  function automatic lam_t lam_next(input lam_t s, input logic b);
    lam_t o;
    logic [24:0] r;
    r = step24(s.rem, b, s.item.energy);
    o = s;
    o.rem = r[23:0];
    o.quo = {s.quo[LAM_W-2:0], r[24]};
    return o;
  endfunction

  function automatic ix_t ix_next(input ix_t s, input logic b, input logic [19:0] d);
    ix_t o;
    logic [20:0] r;
    r = step20(s.rem, b, d);
    o = s;
    o.rem = r[19:0];
    o.quo = {s.quo[QI_W-2:0], r[20]};
    return o;
  endfunction

  function automatic fd_t fd_next(input fd_t s, input logic b, input logic [19:0] d);
    fd_t o;
    logic [20:0] r;
    r = step20(s.rem, b, d);
    o = s;
    o.rem = r[19:0];
    o.quo = {s.quo[14:0], r[20]};
    return o;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_wl    <= 20'd0;
      step        <= 20'd256;
      peak        <= 16'hFFFF;
      point_count <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_WL: first_wl    <= cfg_data;
        CFG_STEP:     step        <= cfg_data;
        CFG_PEAK:     peak        <= cfg_data[15:0];
        CFG_COUNT:    point_count <= cfg_data[8:0];
        default:      ;
      endcase
    end
  end

  // whole pipeline moves when the output register can take a result
  assign adv = !out_valid || !out_stall;
  assign pop_req = adv;

  // wavelength divider: one quotient bit per stage
  always_comb begin
    lam_head.valid = head_valid;
    lam_head.item  = head;
    lam_head.rem   = 24'(LAMBDA_NUM[LNUM_W-1:LAM_W]);
    lam_head.quo   = '0;
  end

  genvar k;
  generate
    for (k = 0; k < LAM_W; k++) begin : g_lam
      if (k == 0) begin : g_first
        assign lam_in[k] = lam_next(lam_head, LAMBDA_NUM[LAM_W-1]);
      end else begin : g_rest
        assign lam_in[k] = lam_next(lam_r[k-1], LAMBDA_NUM[LAM_W-1-k]);
      end
      always_ff @(posedge clk) begin
        if (rst) lam_r[k].valid <= 1'b0;
        else if (adv) lam_r[k].valid <= lam_in[k].valid;
        if (adv) begin
          lam_r[k].item <= lam_in[k].item;
          lam_r[k].rem  <= lam_in[k].rem;
          lam_r[k].quo  <= lam_in[k].quo;
        end
      end
    end
  endgenerate

  // wavelength offset and index divider setup
  always_comb begin
    ix_head.valid = lam_r[LAM_W-1].valid;
    ix_head.query = lam_r[LAM_W-1].item.query;
    ix_head.low   = lam_r[LAM_W-1].item.low;
    ix_head.idx   = lam_r[LAM_W-1].item.idx;
    ix_head.val   = lam_r[LAM_W-1].item.val;
    ix_head.dlam  = $signed({1'b0, lam_r[LAM_W-1].quo}) - $signed({10'b0, first_wl});
    ix_head.neg   = ix_head.dlam[LAM_W];
    ix_head.ovf   = !ix_head.neg &&
                    (DW'(ix_head.dlam[LAM_W-1:0]) >= DW'({step, {QI_W{1'b0}}}));
    ix_head.rem   = 20'(ix_head.dlam[LAM_W-1:QI_W]);
    ix_head.quo   = '0;
  end

  generate
    for (k = 0; k <= QI_W; k++) begin : g_ix
      if (k == 0) begin : g_first
        assign ix_in[k] = ix_head;
      end else begin : g_rest
        assign ix_in[k] = ix_next(ix_r[k-1], ix_r[k-1].dlam[QI_W-k], step);
      end
      always_ff @(posedge clk) begin
        if (rst) ix_r[k].valid <= 1'b0;
        else if (adv) ix_r[k].valid <= ix_in[k].valid;
        if (adv) begin
          ix_r[k].query <= ix_in[k].query;
          ix_r[k].low   <= ix_in[k].low;
          ix_r[k].idx   <= ix_in[k].idx;
          ix_r[k].val   <= ix_in[k].val;
          ix_r[k].neg   <= ix_in[k].neg;
          ix_r[k].ovf   <= ix_in[k].ovf;
          ix_r[k].dlam  <= ix_in[k].dlam;
          ix_r[k].rem   <= ix_in[k].rem;
          ix_r[k].quo   <= ix_in[k].quo;
        end
      end
    end
  endgenerate

  // range checks for the table read
  always_comb begin
    cnt = (CW'(point_count) < CW'(TABLE_DEPTH)) ? CW'(point_count) : CW'(TABLE_DEPTH);
    rd_i = ix_r[QI_W].neg ? '0 : ix_r[QI_W].quo;
    rd_zero = ix_r[QI_W].low || (step == 20'd0) || (cnt < CW'(2)) || ix_r[QI_W].ovf ||
              (CW'(rd_i) + CW'(2) > cnt);
  end

  // table: writes and query reads in request order
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ix_r[QI_W].valid && !ix_r[QI_W].query &&
          ({24'd0, ix_r[QI_W].idx} < 32'(TABLE_DEPTH))) begin
        table_mem[IDX_W'(ix_r[QI_W].idx)] <= ix_r[QI_W].val;
      end
      t0 <= table_mem[rd_i[IDX_W-1:0]];
      t1 <= table_mem[IDX_W'(rd_i + 1'b1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_r.valid <= 1'b0;
    else if (adv) rd_r.valid <= ix_r[QI_W].valid;
    if (adv) begin
      rd_r.query <= ix_r[QI_W].query;
      rd_r.zero  <= rd_zero;
      rd_r.frac  <= ix_r[QI_W].neg ? 22'(ix_r[QI_W].dlam) : {2'b00, ix_r[QI_W].rem};
    end
  end

  // interpolation products, sum, and peak scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= rd_r.valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
    if (adv) begin
      m1_query <= rd_r.query;
      m1_zero  <= rd_r.zero;
      m1_p0    <= {20'd0, t0} * {16'd0, step};
      m1_p1    <= 39'($signed({1'b0, t1}) - $signed({1'b0, t0})) * 39'(rd_r.frac);
      m2_query <= m1_query;
      m2_zero  <= m1_zero;
      m2_v     <= 40'($signed({1'b0, m1_p0})) + 40'(m1_p1);
      m3_query <= m2_query;
      m3_zero  <= m2_zero;
      m3_num   <= 57'(m2_v) * 57'($signed({1'b0, peak}));
    end
  end

  // final divide by step, on the value already shifted down by 16
  always_comb begin
    fn = m3_num[55:16];
    fd_head.valid = m3_valid;
    fd_head.query = m3_query;
    fd_head.zero  = m3_zero;
    fd_head.pos   = (m3_num > 57'sd0);
    fd_head.ovf   = (fn >= {4'd0, step, 16'd0});
    fd_head.n     = fn[15:0];
    fd_head.rem   = 20'(fn[39:16]);
    fd_head.quo   = '0;
  end

  generate
    for (k = 0; k <= 16; k++) begin : g_fd
      if (k == 0) begin : g_first
        assign fd_in[k] = fd_head;
      end else begin : g_rest
        assign fd_in[k] = fd_next(fd_r[k-1], fd_r[k-1].n[16-k], step);
      end
      always_ff @(posedge clk) begin
        if (rst) fd_r[k].valid <= 1'b0;
        else if (adv) fd_r[k].valid <= fd_in[k].valid;
        if (adv) begin
          fd_r[k].query <= fd_in[k].query;
          fd_r[k].zero  <= fd_in[k].zero;
          fd_r[k].pos   <= fd_in[k].pos;
          fd_r[k].ovf   <= fd_in[k].ovf;
          fd_r[k].n     <= fd_in[k].n;
          fd_r[k].rem   <= fd_in[k].rem;
          fd_r[k].quo   <= fd_in[k].quo;
        end
      end
    end
  endgenerate

  // output register, queries only
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= fd_r[16].valid && fd_r[16].query;
    if (adv) begin
      if (fd_r[16].zero || !fd_r[16].pos) efficiency <= 16'd0;
      else if (fd_r[16].ovf) efficiency <= 16'hFFFF;
      else efficiency <= fd_r[16].quo;
    end
  end

endmodule

@@ design/photon_qe_curve_interpolator.sv @@
// photon_qe_curve_interpolator: top level, front register, queue and back pipeline
// depends on pqci_pkg, pqci_front, pqci_queue, pqci_back
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   in       | in_valid / in_stall | cmd, point_index, point_value, photon_energy
//   out      | out_valid/out_stall | efficiency
//   cfg      | cfg_we              | cfg_index, cfg_data
//
// one request per clock, sustained while the output is not stalled; the result is registered after
// the request passes the front register, queue, wavelength divider, index divider, table read,
// products, final divider and output register
// write requests give no result and update the table in request order
// synchronous reset clears control state; table contents are undefined until written
// an output stall freezes the whole back pipeline; the queue absorbs the front
module photon_qe_curve_interpolator import pqci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  point_index,
  input  logic [15:0] point_value,
  input  logic [23:0] photon_energy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] efficiency
);

  item_t f_item;
  logic  f_valid;
  logic  f_ready;
  item_t q_head;
  logic  q_valid;
  logic  q_pop;

  pqci_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .point_index, .point_value, .photon_energy,
    .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
  );

  pqci_queue u_queue (
    .clk, .rst,
    .push_item(f_item), .push_valid(f_valid), .push_ready(f_ready),
    .head(q_head), .head_valid(q_valid), .pop_req(q_pop)
  );

  pqci_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .head(q_head), .head_valid(q_valid), .pop_req(q_pop),
    .out_valid, .out_stall, .efficiency
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench of photon_qe_curve_interpolator, table loads and energy queries
// depends on pqci_pkg and the design; holds its own fixed-point predictor in a scoreboard class
module testbench;
  import pqci_pkg::*;

  localparam logic CMD_WRITE = 1'b0;
  localparam int SETTLE = 90;
  localparam int WATCHDOG = 5000;
  localparam int HOLD_LEN = 400;
  localparam int PHASE_ITEMS = 255;

  // scoreboard: expected efficiencies from the fixed-point table interpolation
  class qe_scoreboard;
    logic [15:0] qe_points[TABLE_DEPTH];
    longint first_wl, wl_step, peak, npoints;
    logic [15:0] pending_eff[$];
    int errors;

    function new();
      first_wl = 0;
      wl_step = 256;
      peak = 65535;
      npoints = 0;
      errors = 0;
      foreach (qe_points[k]) qe_points[k] = '0;
    endfunction

    function void set_reg(cfg_idx_t r, logic [19:0] d);
      case (r)
        CFG_FIRST_WL: first_wl = d;
        CFG_STEP:     wl_step = d;
        CFG_PEAK:     peak = d[15:0];
        CFG_COUNT:    npoints = d[8:0];
        default: ;
      endcase
    endfunction

    // returns 1 when the query reads entries idx and idx+1
    function bit table_index(logic [23:0] e, output longint idx, output longint dlam);
      longint cnt, lam;
      idx = 0;
      dlam = 0;
      if (e < ENERGY_MIN || wl_step == 0) return 0;
      cnt = (npoints < TABLE_DEPTH) ? npoints : TABLE_DEPTH;
      if (cnt < 2) return 0;
      lam = (longint'(1240) << 28) / longint'(e);
      dlam = lam - first_wl;
      idx = (dlam < 0) ? 0 : dlam / wl_step;
      return idx <= cnt - 2;
    endfunction

    function logic [15:0] predict_eff(logic [23:0] e);
      longint idx, dlam, frac, t0, t1, num, q;
      if (!table_index(e, idx, dlam)) return '0;
      frac = dlam - idx * wl_step;
      t0 = qe_points[idx];
      t1 = qe_points[idx + 1];
      num = (t0 * wl_step + (t1 - t0) * frac) * peak;
      if (num <= 0) return '0;
      q = num / (wl_step << 16);
      return (q > 65535) ? 16'hffff : q[15:0];
    endfunction

    function void note_request(logic c, logic [7:0] idx, logic [15:0] val, logic [23:0] e);
      if (c == CMD_WRITE) qe_points[idx] = val;
      else pending_eff.push_back(predict_eff(e));
    endfunction

    function void check_efficiency(logic [15:0] got);
      logic [15:0] want;
      if (pending_eff.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: efficiency %0d", got);
        return;
      end
      want = pending_eff.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("efficiency mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [7:0]  point_index = '0;
  logic [15:0] point_value = '0;
  logic [23:0] photon_energy = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] efficiency;

  qe_scoreboard sb = new();
  bit written[TABLE_DEPTH];
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet = 0;

  photon_qe_curve_interpolator u_top (.*);

  always #2 clk = ~clk;

  // receiver side: check accepted results, then pick next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_efficiency(efficiency);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with work pending but no handshake
  always @(posedge clk) begin
    if (!rst && (in_valid || sb.pending_eff.size() != 0)) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // offer one request and wait for its acceptance
  task automatic send_request(logic c, logic [7:0] idx, logic [15:0] val, logic [23:0] e);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    point_index <= idx;
    point_value <= val;
    photon_energy <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c, idx, val, e);
  endtask

  task automatic send_write(logic [7:0] idx, logic [15:0] val);
    written[idx] = 1;
    send_request(CMD_WRITE, idx, val, 24'($urandom()));
  endtask

  // query, loading any entry it reads that was never written
  task automatic send_query(logic [23:0] e);
    longint idx, dlam;
    if (sb.table_index(e, idx, dlam)) begin
      if (!written[idx]) send_write(8'(idx), 16'($urandom()));
      if (!written[idx + 1]) send_write(8'(idx + 1), 16'($urandom()));
    end
    send_request(CMD_QUERY, 8'($urandom()), 16'($urandom()), e);
  endtask

  // energy whose wavelength lands near a chosen table position
  function automatic logic [23:0] energy_at(longint lam);
    longint e;
    if (lam < 19841) return 24'(24'hffffff - $urandom_range(0, 4095));
    e = (longint'(1240) << 28) / lam;
    return (e < ENERGY_MIN) ? ENERGY_MIN : e[23:0];
  endfunction

  // wait for the pipeline to empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_eff.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_config(logic [19:0] fw, logic [19:0] st, logic [15:0] pk, logic [8:0] n);
    cfg_idx_t r;
    logic [19:0] d;
    for (int k = 0; k < 4; k++) begin
      r = cfg_idx_t'(k);
      case (r)
        CFG_FIRST_WL: d = fw;
        CFG_STEP:     d = st;
        CFG_PEAK:     d = {4'd0, pk};
        default:      d = {11'd0, n};
      endcase
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_data <= d;
      @(posedge clk);
      sb.set_reg(r, d);
    end
    cfg_we <= 1'b0;
  endtask

  // one random phase: mostly targeted queries, some loads and noise
  task automatic random_phase(int base);
    int roll;
    longint lam, cnt;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (base + n < 3 * PHASE_ITEMS) begin
        gap_pct = 18;
        stall_pct = 63;
      end else if (base + n < 5 * PHASE_ITEMS) begin
        gap_pct = 63;
        stall_pct = 18;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      roll = $urandom_range(0, 99);
      cnt = (sb.npoints < 2) ? 2 : ((sb.npoints > TABLE_DEPTH) ? TABLE_DEPTH : sb.npoints);
      if (roll < 20) begin
        send_write(8'($urandom()), 16'($urandom()));
      end else if (roll < 70) begin
        lam = sb.first_wl + longint'($urandom_range(0, cnt)) * sb.wl_step
              + $urandom_range(0, (sb.wl_step > 0) ? sb.wl_step - 1 : 0);
        if ($urandom_range(0, 9) == 0) lam = sb.first_wl - $urandom_range(0, 100000);
        send_query(energy_at(lam));
      end else if (roll < 85) begin
        send_query(24'($urandom()));
      end else if (roll < 95) begin
        send_query(24'($urandom_range(0, ENERGY_MIN - 1)));
      end else begin
        send_query($urandom_range(0, 1) ? 24'hffffff : 24'(ENERGY_MIN + $urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    longint below;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, low-energy floor, too few points, saturation both ways
    apply_config(20'd51200, 20'd2560, 16'hffff, 9'd1);
    send_write(8'd255, 16'hffff);
    send_write(8'd0, 16'h0000);
    send_query(24'd0);
    send_query(24'd5000000);
    drain();
    apply_config(20'd51200, 20'd2560, 16'hffff, 9'd16);
    send_query(24'd1048);
    send_query(ENERGY_MIN);
    send_query(24'hffffff);
    below = 51200 - 25600;
    send_write(8'd0, 16'd60000);
    send_write(8'd1, 16'd30000);
    send_query(energy_at(below));
    send_query(energy_at(51200));
    send_query(energy_at(51200 + 1280));
    send_write(8'd0, 16'd0);
    send_write(8'd1, 16'hffff);
    send_query(energy_at(below));
    send_query(energy_at(51200 + 15 * 2560));
    send_query(energy_at(51200 + 14 * 2560 + 2559));
    drain();

    // random phases over several register settings
    apply_config(20'd0, 20'hfffff, 16'd0, 9'd2);
    random_phase(0);
    drain();
    apply_config(20'hfffff, 20'd4096, 16'hffff, 9'd256);
    random_phase(PHASE_ITEMS);
    drain();
    apply_config(20'd25600, 20'd256, 16'd40000, 9'd511);
    hold_req = 1;
    random_phase(2 * PHASE_ITEMS);
    drain();
    apply_config(20'd0, 20'd0, 16'd12345, 9'd100);
    random_phase(3 * PHASE_ITEMS);
    drain();
    apply_config(20'd5000, 20'd37, 16'hffff, 9'd200);
    random_phase(4 * PHASE_ITEMS);
    drain();
    apply_config(20'd19840, 20'd1, 16'd1, 9'd0);
    random_phase(5 * PHASE_ITEMS);
    drain();

    if (sb.errors == 0 && sb.pending_eff.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ photon_qe_curve_interpolator.f @@
design/pqci_pkg.sv
design/pqci_front.sv
design/pqci_queue.sv
design/pqci_back.sv
design/photon_qe_curve_interpolator.sv
verif/testbench.sv
